### sv/mpfla_pkg.sv
// shared types and codes for the multi-pool free-list slot allocator
// no dependencies; imported by every module of the block except mpfla_ram
`default_nettype none

package mpfla_pkg;

    // request codes carried on s_tuser
    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_GET     = 2'd2,
        CMD_PUT     = 2'd3
    } cmd_t;

    // result codes carried on m_tuser
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_POOL  = 3'd1,
        ST_NO_SLOT  = 3'd2,
        ST_INACTIVE = 3'd3,
        ST_BAD      = 3'd4
    } status_t;

    localparam int QUEUE_DEPTH = 2;

    // classified request as it waits between front and back
    typedef struct packed {
        cmd_t       cmd;
        logic [2:0] pid;
        logic [7:0] slot;
        logic [8:0] cnt;
        logic       pid_ok;
        logic       cnt_ok;
    } req_entry_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

    typedef struct packed {
        status_t    status;
        logic [2:0] pool;
        logic [7:0] slot;
        logic [8:0] freec;
    } result_t;

endpackage

`default_nettype wire

### sv/multi_pool_free_list_allocator.sv
// multi-pool free-list slot allocator: top level
// depends on mpfla_pkg, mpfla_front, mpfla_queue, mpfla_back (and mpfla_ram)
//
// usage
// - one request on the s_ stream gives exactly one result on the m_ stream, in order
// - requests: create a pool (lowest free pool id, initial slot count), destroy a
//   pool, get a slot from a pool, put a slot back to a pool
// - get pops the pool's lifo free list; when it is empty it hands out the next
//   never-used slot, doubling the pool capacity up to POOL_DEPTH as needed
// - an accepted request waits in the request queue until the back end is free, and its
//   result is then written to the result register that drives m_tvalid
// - throughput: one request per cycle while m_tready takes each result, for create, destroy, put and a get that
//   empties the free list or takes a fresh slot; a get that pops a free list with more
//   entries holds the back end in a link state for the registered read of the link ram
// - the front end accepts into a two-entry request queue, so s_tready stays high
//   for up to two more requests while a finished result waits on m_tready
// - when m_tready is low the result register holds, the back end stops, the
//   queue fills and then s_tready drops
// - reset (aresetn low, synchronous) marks every pool inactive and empties the
//   queue and the result register; the link ram needs no clearing since a link
//   is only read after it was written
`default_nettype none

module multi_pool_free_list_allocator #(
    parameter int NUM_POOLS  = 8,
    parameter int POOL_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // pool_id[2:0], slot_index[10:3], slot_count[19:11]
    input  wire logic [1:0]  s_tuser,   // command[1:0]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // granted_pool[2:0], granted_slot[10:3], free_slots[19:11]
    output logic [2:0]       m_tuser    // status[2:0]
);
    import mpfla_pkg::*;

    // request handoff between front end and back end
    logic       q_push, q_pop;
    req_entry_t push_entry, head_entry;
    q_status_t  q_stat;
    result_t    res;

    // classify incoming requests
    mpfla_front #(
        .NUM_POOLS  (NUM_POOLS),
        .POOL_DEPTH (POOL_DEPTH)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    // decouples acceptance from execution
    mpfla_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head_entry (head_entry),
        .stat       (q_stat)
    );

    // pool state, link ram and the result register
    mpfla_back #(
        .NUM_POOLS  (NUM_POOLS),
        .POOL_DEPTH (POOL_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .q_entry  (head_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (res)
    );

    // pack the result fields, lowest first
    assign m_tdata = {4'b0000, res.freec, res.slot, res.pool};
    assign m_tuser = res.status;

    // queue never takes a request while full
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_stat.full))
        else $error("request queue overflow");

    // back end only pops a waiting request
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_stat.valid)
        else $error("pop from empty request queue");

    // a new result only follows a request taken by the back end
    a_result_from_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(q_pop))
        else $error("result without a request");

    // reset leaves no pending request or result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !q_stat.valid))
        else $error("state left after reset");

endmodule

`default_nettype wire

### sv/mpfla_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module mpfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### sv/mpfla_front.sv
// front end: takes requests off the input stream and classifies them
// depends on mpfla_pkg
`default_nettype none

module mpfla_front #(
    parameter int NUM_POOLS  = 8,
    parameter int POOL_DEPTH = 256
) (
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [23:0]            s_tdata,
    input  wire logic [1:0]             s_tuser,
    input  wire mpfla_pkg::q_status_t   q_stat,
    output logic                        q_push,
    output mpfla_pkg::req_entry_t       q_entry
);
    import mpfla_pkg::*;

    logic [31:0] cnt_w;

    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        cnt_w          = 32'(s_tdata[19:11]);
        q_entry.cmd    = cmd_t'(s_tuser);
        q_entry.pid    = s_tdata[2:0];
        q_entry.slot   = s_tdata[10:3];
        q_entry.cnt    = s_tdata[19:11];
        // pool ids past the configured count behave as inactive pools
        q_entry.pid_ok = 32'(s_tdata[2:0]) < 32'(NUM_POOLS);
        q_entry.cnt_ok = (cnt_w != 32'd0) && (cnt_w <= 32'(POOL_DEPTH));
    end

endmodule

`default_nettype wire

### sv/mpfla_queue.sv
// short request queue between the front end and the back end
// depends on mpfla_pkg
`default_nettype none

module mpfla_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire mpfla_pkg::req_entry_t push_entry,
    input  wire logic                  pop,
    output mpfla_pkg::req_entry_t      head_entry,
    output mpfla_pkg::q_status_t       stat
);
    import mpfla_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    req_entry_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (32'(p) == QUEUE_DEPTH - 1) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign head_entry = entry_reg[rd_ptr_reg];
    assign stat.full  = (32'(count_reg) == QUEUE_DEPTH);
    assign stat.valid = (count_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

### sv/mpfla_back.sv
// back end: per-pool state, link ram and result register; executes requests
// depends on mpfla_pkg and mpfla_ram
`default_nettype none

module mpfla_back #(
    parameter int NUM_POOLS  = 8,
    parameter int POOL_DEPTH = 256
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire mpfla_pkg::q_status_t  q_stat,
    input  wire mpfla_pkg::req_entry_t q_entry,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output mpfla_pkg::result_t         m_res
);
    import mpfla_pkg::*;

    localparam int POOL_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int SLOT_W = $clog2(POOL_DEPTH);
    localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
    localparam int LINK_DEPTH = 1 << (POOL_W + SLOT_W);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(POOL_DEPTH);
    localparam logic [CNT_W:0]   DEPTH_X = (CNT_W + 1)'(POOL_DEPTH);

    typedef enum logic {
        S_EXEC,
        S_LINK
    } state_t;

    state_t            state_reg, state_next;
    logic [POOL_W-1:0] link_pool_reg, link_pool_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic [SLOT_W-1:0] head_reg   [NUM_POOLS];
    logic [SLOT_W-1:0] head_next  [NUM_POOLS];
    logic [NUM_POOLS-1:0] hvalid_reg, hvalid_next;
    logic [NUM_POOLS-1:0] active_reg, active_next;
    logic [CNT_W-1:0]  fresh_reg  [NUM_POOLS];
    logic [CNT_W-1:0]  fresh_next [NUM_POOLS];
    logic [CNT_W-1:0]  cap_reg    [NUM_POOLS];
    logic [CNT_W-1:0]  cap_next   [NUM_POOLS];
    logic [CNT_W-1:0]  inuse_reg  [NUM_POOLS];
    logic [CNT_W-1:0]  inuse_next [NUM_POOLS];

    logic                     ram_we;
    logic [POOL_W+SLOT_W-1:0] ram_waddr, ram_raddr;
    logic [SLOT_W-1:0]        ram_wdata, ram_rdata;

    logic              fire, act, any_free;
    logic [8:0]        pid_w, found_w;
    logic [POOL_W-1:0] pidx, found;
    logic [31:0]       slot_w, cnt_w, gslot_w, freec_w;
    logic [SLOT_W-1:0] sidx;
    logic [CNT_W-1:0]  cap, fr, iu, cap_n, iu_n;
    logic [CNT_W:0]    dbl;

    mpfla_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // lowest inactive pool for create
    always_comb begin
        found    = '0;
        any_free = 1'b0;
        for (int p = NUM_POOLS - 1; p >= 0; p--) begin
            if (!active_reg[p]) begin
                found    = POOL_W'(p);
                any_free = 1'b1;
            end
        end
    end

    always_comb begin
        pid_w   = 9'(q_entry.pid);
        pidx    = pid_w[POOL_W-1:0];
        found_w = 9'(found);
        slot_w  = 32'(q_entry.slot);
        sidx    = slot_w[SLOT_W-1:0];
        cnt_w   = 32'(q_entry.cnt);
        act     = q_entry.pid_ok && active_reg[pidx];
        cap     = cap_reg[pidx];
        fr      = fresh_reg[pidx];
        iu      = inuse_reg[pidx];
        cap_n   = cap;
        iu_n    = iu;
        dbl     = {cap, 1'b0};
        gslot_w = '0;
        freec_w = '0;

        head_next   = head_reg;
        hvalid_next = hvalid_reg;
        active_next = active_reg;
        fresh_next  = fresh_reg;
        cap_next    = cap_reg;
        inuse_next  = inuse_reg;

        state_next     = state_reg;
        link_pool_next = link_pool_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        ram_we    = 1'b0;
        ram_waddr = {pidx, sidx};
        ram_wdata = head_reg[pidx];
        ram_raddr = {pidx, head_reg[pidx]};

        fire  = (state_reg == S_EXEC) && q_stat.valid && (!out_valid_reg || m_tready);
        q_pop = fire;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_LINK: begin
                // registered link read has landed: it is the new list top
                head_next[link_pool_reg] = ram_rdata;
                state_next               = S_EXEC;
            end
            S_EXEC: begin
                if (fire) begin
                    out_valid_next = 1'b1;
                    out_next.status = ST_OK;
                    out_next.pool   = q_entry.pid;
                    out_next.slot   = '0;
                    out_next.freec  = '0;
                    if (q_entry.cmd == CMD_CREATE) begin
                        if (!any_free) begin
                            out_next.status = ST_NO_POOL;
                        end else if (!q_entry.cnt_ok) begin
                            out_next.status = ST_BAD;
                        end else begin
                            head_next[found]   = '0;
                            hvalid_next[found] = 1'b0;
                            active_next[found] = 1'b1;
                            fresh_next[found]  = '0;
                            cap_next[found]    = cnt_w[CNT_W-1:0];
                            inuse_next[found]  = '0;
                            out_next.pool      = found_w[2:0];
                            out_next.freec     = q_entry.cnt;
                        end
                    end else if (!act) begin
                        out_next.status = ST_INACTIVE;
                    end else begin
                        unique case (q_entry.cmd)
                            CMD_DESTROY: begin
                                head_next[pidx]   = '0;
                                hvalid_next[pidx] = 1'b0;
                                active_next[pidx] = 1'b0;
                                fresh_next[pidx]  = '0;
                                cap_next[pidx]    = '0;
                                inuse_next[pidx]  = '0;
                            end
                            CMD_GET: begin
                                if (hvalid_reg[pidx]) begin
                                    // pop the free list
                                    gslot_w = 32'(head_reg[pidx]);
                                    iu_n    = iu + CNT_W'(1);
                                    if (fr > iu_n) begin
                                        state_next     = S_LINK;
                                        link_pool_next = pidx;
                                    end else begin
                                        hvalid_next[pidx] = 1'b0;
                                    end
                                end else begin
                                    // grow by doubling once fresh slots run out
                                    if (fr >= cap && cap < DEPTH_C) begin
                                        cap_n = (dbl > DEPTH_X) ? DEPTH_C : dbl[CNT_W-1:0];
                                    end
                                    cap_next[pidx] = cap_n;
                                    if (fr < cap_n) begin
                                        gslot_w          = 32'(fr);
                                        fresh_next[pidx] = fr + CNT_W'(1);
                                        iu_n             = iu + CNT_W'(1);
                                    end else begin
                                        out_next.status = ST_NO_SLOT;
                                    end
                                end
                                inuse_next[pidx] = iu_n;
                            end
                            CMD_PUT: begin
                                if (iu == '0 || slot_w >= 32'(fr)) begin
                                    out_next.status = ST_BAD;
                                end else begin
                                    ram_we            = 1'b1;
                                    head_next[pidx]   = sidx;
                                    hvalid_next[pidx] = 1'b1;
                                    iu_n              = iu - CNT_W'(1);
                                    inuse_next[pidx]  = iu_n;
                                end
                            end
                            default: begin
                            end
                        endcase
                        freec_w        = 32'(cap_n - iu_n);
                        out_next.slot  = gslot_w[7:0];
                        out_next.freec = (q_entry.cmd == CMD_DESTROY) ? 9'd0 : freec_w[8:0];
                    end
                end
            end
            default: begin
                state_next = S_EXEC;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_res    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_EXEC;
            out_valid_reg <= 1'b0;
            hvalid_reg    <= '0;
            active_reg    <= '0;
            for (int p = 0; p < NUM_POOLS; p++) begin
                head_reg[p]  <= '0;
                fresh_reg[p] <= '0;
                cap_reg[p]   <= '0;
                inuse_reg[p] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            hvalid_reg    <= hvalid_next;
            active_reg    <= active_next;
            head_reg      <= head_next;
            fresh_reg     <= fresh_next;
            cap_reg       <= cap_next;
            inuse_reg     <= inuse_next;
        end
        link_pool_reg <= link_pool_next;
        out_reg       <= out_next;
    end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// self-checking testbench for multi_pool_free_list_allocator: directed and random
// requests on the s_ stream, results on the m_ stream checked against a local pool model
// depends on mpfla_pkg and the allocator rtl
`timescale 1ns / 100ps

module testbench;
    import mpfla_pkg::*;

    localparam int NUM_POOLS    = 8;
    localparam int POOL_DEPTH   = 256;
    localparam int RANDOM_ITEMS = 1550;
    localparam int DRAIN_AT     = 500;     // request count where one pool is emptied to the top
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_LEN     = 300;     // long receiver hold-off, in cycles

    // two copies of the pool model: one steers stimulus, one tracks accepted requests
    localparam int SHADOW = 0;
    localparam int LIVE   = 1;

    typedef struct packed {
        cmd_t       cmd;
        logic [2:0] pid;
        logic [7:0] slot;
        logic [8:0] cnt;
    } alloc_req_t;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_THIRD, RX_RARE} recv_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;

    // pool model state, indexed by model copy then pool
    logic [7:0]  free_link [2][NUM_POOLS][POOL_DEPTH];
    int unsigned top_slot  [2][NUM_POOLS];
    bit          top_ok    [2][NUM_POOLS];
    int unsigned next_fresh[2][NUM_POOLS];
    int unsigned pool_cap  [2][NUM_POOLS];
    int unsigned pool_used [2][NUM_POOLS];
    bit          pool_on   [2][NUM_POOLS];

    // slots the stimulus believes are handed out, used to aim puts
    bit          held_slot [NUM_POOLS][POOL_DEPTH];

    alloc_req_t  pending_reqs[$];
    result_t     expected_results[$];
    int          total_items;
    int          accepted_count = 0;
    int          result_count   = 0;
    int          errors         = 0;
    int          cycle_count    = 0;
    int          burst_left     = 1;
    int          gap_left       = 0;
    int          hold_cycles    = 0;
    int          holds_done     = 0;
    int          stall_tick     = 0;
    recv_mode_t  stall_mode     = RX_FREE;

    always #5 aclk = ~aclk;

    multi_pool_free_list_allocator #(
        .NUM_POOLS (NUM_POOLS),
        .POOL_DEPTH(POOL_DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // pool_id[2:0], slot_index[10:3], slot_count[19:11]
        .s_tuser (s_tuser),   // command[1:0]
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),   // granted_pool[2:0], granted_slot[10:3], free_slots[19:11]
        .m_tuser (m_tuser)    // status[2:0]
    );

    function automatic void clear_pool(input int c, input int p);
        top_slot[c][p]   = 0;
        top_ok[c][p]     = 1'b0;
        next_fresh[c][p] = 0;
        pool_cap[c][p]   = 0;
        pool_used[c][p]  = 0;
        pool_on[c][p]    = 1'b0;
    endfunction

    // allocator behavior for one request on model copy c
    function automatic result_t apply_request(input int c, input alloc_req_t r);
        result_t res;
        int      p;
        int      i;
        int      found;
        p          = r.pid;
        res.status = ST_OK;
        res.pool   = r.pid;
        res.slot   = '0;
        res.freec  = '0;
        if (r.cmd == CMD_CREATE) begin
            found = -1;
            for (i = NUM_POOLS - 1; i >= 0; i--)
                if (!pool_on[c][i]) found = i;
            // a full pool table wins over a bad count
            if (found < 0) begin
                res.status = ST_NO_POOL;
            end else if (r.cnt == 0 || r.cnt > POOL_DEPTH) begin
                res.status = ST_BAD;
            end else begin
                clear_pool(c, found);
                pool_on[c][found]  = 1'b1;
                pool_cap[c][found] = r.cnt;
                res.pool           = 3'(found);
                res.freec          = r.cnt;
            end
        end else if (!pool_on[c][p]) begin
            res.status = ST_INACTIVE;
        end else if (r.cmd == CMD_DESTROY) begin
            clear_pool(c, p);
        end else if (r.cmd == CMD_GET) begin
            if (top_ok[c][p]) begin
                res.slot = 8'(top_slot[c][p]);
                pool_used[c][p]++;
                // list length is fresh minus used, so the link was written before
                if (next_fresh[c][p] > pool_used[c][p])
                    top_slot[c][p] = free_link[c][p][res.slot];
                else
                    top_ok[c][p] = 1'b0;
            end else begin
                if (next_fresh[c][p] >= pool_cap[c][p] && pool_cap[c][p] < POOL_DEPTH)
                    pool_cap[c][p] = (pool_cap[c][p] * 2 > POOL_DEPTH) ? POOL_DEPTH
                                                                       : pool_cap[c][p] * 2;
                if (next_fresh[c][p] < pool_cap[c][p]) begin
                    res.slot = 8'(next_fresh[c][p]);
                    next_fresh[c][p]++;
                    pool_used[c][p]++;
                end else begin
                    res.status = ST_NO_SLOT;
                end
            end
            res.freec = 9'(pool_cap[c][p] - pool_used[c][p]);
        end else begin
            // put of a slot never handed out, or into an empty pool, is refused
            if (pool_used[c][p] == 0 || r.slot >= next_fresh[c][p]) begin
                res.status = ST_BAD;
            end else begin
                free_link[c][p][r.slot] = 8'(top_slot[c][p]);
                top_slot[c][p]          = r.slot;
                top_ok[c][p]            = 1'b1;
                pool_used[c][p]--;
            end
            res.freec = 9'(pool_cap[c][p] - pool_used[c][p]);
        end
        return res;
    endfunction

    // append one request to the stimulus and advance the steering model
    function automatic result_t queue_request(input cmd_t cmd, input int pid,
                                              input int slot, input int cnt);
        alloc_req_t r;
        result_t    res;
        int         i;
        r.cmd  = cmd;
        r.pid  = 3'(pid);
        r.slot = 8'(slot);
        r.cnt  = 9'(cnt);
        pending_reqs.push_back(r);
        res = apply_request(SHADOW, r);
        if (res.status == ST_OK) begin
            case (cmd)
                CMD_CREATE, CMD_DESTROY: begin
                    for (i = 0; i < POOL_DEPTH; i++) held_slot[res.pool][i] = 1'b0;
                end
                CMD_GET: held_slot[r.pid][res.slot] = 1'b1;
                CMD_PUT: held_slot[r.pid][r.slot]   = 1'b0;
            endcase
        end
        return res;
    endfunction

    function automatic int pick_active();
        int start;
        int k;
        start = $urandom_range(0, NUM_POOLS - 1);
        for (k = 0; k < NUM_POOLS; k++)
            if (pool_on[SHADOW][(start + k) % NUM_POOLS]) return (start + k) % NUM_POOLS;
        return -1;
    endfunction

    function automatic int pick_held(input int p);
        int start;
        int k;
        start = $urandom_range(0, POOL_DEPTH - 1);
        for (k = 0; k < POOL_DEPTH; k++)
            if (held_slot[p][(start + k) % POOL_DEPTH]) return (start + k) % POOL_DEPTH;
        return -1;
    endfunction

    // stimulus build, reset and end of run
    initial begin
        result_t res;
        int      p;
        int      s;
        int      r;
        int      target;
        bit      drained;
        int      i;
        for (i = 0; i < NUM_POOLS; i++) begin
            clear_pool(SHADOW, i);
            clear_pool(LIVE, i);
        end
        for (i = 0; i < NUM_POOLS * POOL_DEPTH; i++) begin
            free_link[SHADOW][i / POOL_DEPTH][i % POOL_DEPTH] = '0;
            free_link[LIVE][i / POOL_DEPTH][i % POOL_DEPTH]   = '0;
            held_slot[i / POOL_DEPTH][i % POOL_DEPTH]         = 1'b0;
        end

        // directed: inactive pools, bad counts, growth, pops, refused and repeated puts
        void'(queue_request(CMD_GET, 0, 0, 0));
        void'(queue_request(CMD_DESTROY, 5, 0, 0));
        void'(queue_request(CMD_CREATE, 6, 0, 0));
        void'(queue_request(CMD_CREATE, 3, 255, 511));
        void'(queue_request(CMD_CREATE, 0, 0, 257));
        void'(queue_request(CMD_CREATE, 0, 0, 1));
        void'(queue_request(CMD_PUT, 0, 0, 0));        // nothing handed out yet
        void'(queue_request(CMD_GET, 0, 0, 0));
        void'(queue_request(CMD_GET, 0, 0, 0));        // capacity doubles
        void'(queue_request(CMD_GET, 0, 0, 0));
        void'(queue_request(CMD_PUT, 0, 200, 0));      // beyond the fresh pointer
        void'(queue_request(CMD_PUT, 0, 1, 0));
        void'(queue_request(CMD_PUT, 0, 0, 0));
        void'(queue_request(CMD_GET, 0, 0, 0));        // pop with a link read
        void'(queue_request(CMD_GET, 0, 0, 0));        // back-to-back pop
        void'(queue_request(CMD_PUT, 0, 2, 0));
        void'(queue_request(CMD_PUT, 0, 2, 0));        // duplicate put
        void'(queue_request(CMD_GET, 0, 0, 0));
        void'(queue_request(CMD_CREATE, 7, 0, 256));
        for (i = 2; i < NUM_POOLS; i++) void'(queue_request(CMD_CREATE, 0, 0, 3));
        void'(queue_request(CMD_CREATE, 5, 0, 0));     // table full takes priority
        void'(queue_request(CMD_DESTROY, 0, 0, 0));
        void'(queue_request(CMD_GET, 7, 0, 0));
        void'(queue_request(CMD_PUT, 7, 0, 0));

        // random: mostly requests aimed at live pools and held slots, some noise
        target  = pending_reqs.size() + RANDOM_ITEMS;
        drained = 1'b0;
        while (pending_reqs.size() < target) begin
            p = pick_active();
            r = $urandom_range(0, 99);
            if (!drained && pending_reqs.size() >= DRAIN_AT) begin
                // run one pool up to full depth and past it
                drained = 1'b1;
                if (p < 0) begin
                    res = queue_request(CMD_CREATE, 0, 0, 256);
                    p   = res.pool;
                end
                do
                    res = queue_request(CMD_GET, p, $urandom_range(0, 255), $urandom_range(0, 511));
                while (res.status == ST_OK);
                void'(queue_request(CMD_GET, p, 0, 0));
            end else if (p < 0 || r < 8) begin
                s = $urandom_range(0, 9);
                void'(queue_request(CMD_CREATE, $urandom_range(0, 7), $urandom_range(0, 255),
                                    s < 6 ? $urandom_range(1, 8) :
                                    s < 9 ? $urandom_range(1, 256) : $urandom_range(0, 511)));
            end else if (r < 13) begin
                void'(queue_request(CMD_DESTROY, p, $urandom_range(0, 255), $urandom_range(0, 511)));
            end else if (r < 60) begin
                void'(queue_request(CMD_GET, $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : p,
                                    $urandom_range(0, 255), $urandom_range(0, 511)));
            end else if (r < 92) begin
                s = pick_held(p);
                if (s < 0 || $urandom_range(0, 6) == 0)
                    void'(queue_request(CMD_PUT, $urandom_range(0, 7), $urandom_range(0, 255),
                                        $urandom_range(0, 511)));
                else
                    void'(queue_request(CMD_PUT, p, s, $urandom_range(0, 511)));
            end else begin
                void'(queue_request(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 7),
                                    $urandom_range(0, 255), $urandom_range(0, 511)));
            end
        end
        total_items = pending_reqs.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_count < total_items || result_count < accepted_count)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (errors == 0 && result_count == accepted_count) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // request driver: bursts of random length with random gaps
    always @(posedge aclk) begin
        alloc_req_t took;
        alloc_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                took.cmd  = cmd_t'(s_tuser);
                took.pid  = s_tdata[2:0];
                took.slot = s_tdata[10:3];
                took.cnt  = s_tdata[19:11];
                expected_results.push_back(apply_request(LIVE, took));
                accepted_count <= accepted_count + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    nxt = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, nxt.cnt, nxt.slot, nxt.pid};
                    s_tuser  <= nxt.cmd;
                    if (burst_left > 1) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-offs so the request queue fills and s_tready drops
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cycles <= 0;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (holds_done < 2 && accepted_count >= 300 + holds_done * 600) begin
            hold_cycles <= HOLD_LEN;
            holds_done  <= holds_done + 1;
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge aclk) begin
        result_t want;
        bit      bad;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                // accepted_count still holds its value from before this edge
                if (result_count >= accepted_count) begin
                    $display("%0t: unexpected result, status %0d tdata %h", $time, m_tuser, m_tdata);
                    errors <= errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    bad  = 1'b0;
                    if (m_tuser !== want.status) begin
                        $display("%0t: status expected %0d got %0d", $time, want.status, m_tuser);
                        bad = 1'b1;
                    end
                    if (m_tdata[2:0] !== want.pool) begin
                        $display("%0t: granted_pool expected %0d got %0d", $time, want.pool,
                                 m_tdata[2:0]);
                        bad = 1'b1;
                    end
                    if (m_tdata[10:3] !== want.slot) begin
                        $display("%0t: granted_slot expected %0d got %0d", $time, want.slot,
                                 m_tdata[10:3]);
                        bad = 1'b1;
                    end
                    if (m_tdata[19:11] !== want.freec) begin
                        $display("%0t: free_slots expected %0d got %0d", $time, want.freec,
                                 m_tdata[19:11]);
                        bad = 1'b1;
                    end
                    if (bad) errors <= errors + 1;
                end
                result_count <= result_count + 1;
            end
            stall_tick <= stall_tick + 1;
            if (stall_tick % 64 == 0) stall_mode <= recv_mode_t'($urandom_range(0, 3));
            if (hold_cycles != 0) begin
                m_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    RX_FREE:  m_tready <= 1'b1;
                    RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
                    RX_THIRD: m_tready <= (stall_tick % 3 != 0);
                    default:  m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("testbench failed");
            $finish;
        end
    end

endmodule
